/* sv/cf_time_units_parser_defines.svh */
// Assertion macros shared by the time-units parser RTL.
`ifndef CF_TIME_UNITS_PARSER_DEFINES_SVH
`define CF_TIME_UNITS_PARSER_DEFINES_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define CTU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds while reset is asserted.
`define CTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTU_ASSERT(lbl, clk, rst, prop, msg)
`define CTU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/ctu_pkg.sv */
// Types, constants and step functions of the time-units parser.
package ctu_pkg;

  // Parse phase of the reference text.
  typedef enum logic [3:0] {
    PH_UNIT, PH_YEAR, PH_MONTH, PH_DAY, PH_PRE_T, PH_POST_T, PH_HOUR,
    PH_MIN, PH_SEC, PH_TAIL, PH_IGNORE, PH_END
  } phase_t;

  typedef enum logic [1:0] {NUM_WS, NUM_SIGN, NUM_DIG} num_sub_t;
  typedef enum logic [1:0] {NUM_GO, NUM_OK, NUM_BAD} num_res_t;

  typedef enum logic [3:0] {
    TL_START, TL_FRAC, TL_SPACE, TL_OH1, TL_OH2, TL_COLON, TL_OM1, TL_OM2, TL_DONE
  } tl_phase_t;

  localparam logic [1:0] UNIT_SEC  = 2'd0;
  localparam logic [1:0] UNIT_MIN  = 2'd1;
  localparam logic [1:0] UNIT_HOUR = 2'd2;
  localparam logic [1:0] UNIT_DAY  = 2'd3;

  localparam logic [55:0] SINCE_PATTERN = 56'h2073696E636520;
  localparam logic [35:0] MAG_SAT = 36'd2147483649;

  typedef struct packed {
    num_sub_t    sub;
    logic        sign;
    logic [31:0] acc;
  } num_t;

  typedef struct packed {
    num_t     n;
    num_res_t r;
  } num_step_t;

  typedef struct packed {
    tl_phase_t  ph;
    logic       neg;
    logic [6:0] hours;
    logic [6:0] mins;
  } tail_t;

  typedef struct packed {
    tail_t t;
    logic  bad;
  } tail_step_t;

  // Status of the unit-word search for the current character.
  typedef struct packed {
    logic       found;
    logic       good;
    logic [1:0] code;
  } unit_res_t;

  localparam num_t  NUM_RESET  = '{sub: NUM_WS, sign: 1'b0, acc: 32'd0};
  localparam tail_t TAIL_RESET = '{ph: TL_START, neg: 1'b0, hours: 7'd0, mins: 7'd0};

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Multiply by ten and add a digit, saturating just above the signed 32-bit range.
  function automatic num_t num_add(input num_t n, input logic [7:0] c);
    logic [35:0] p;
    num_t        r;
    r = n;
    p = ({4'd0, n.acc} << 3) + ({4'd0, n.acc} << 1) + {32'd0, c[3:0]};
    r.acc = (p > MAG_SAT) ? MAG_SAT[31:0] : p[31:0];
    return r;
  endfunction

  function automatic logic num_in_range(input num_t n);
    return n.acc <= (n.sign ? 32'h8000_0000 : 32'h7FFF_FFFF);
  endfunction

  function automatic logic [31:0] num_value(input num_t n);
    return n.sign ? (32'd0 - n.acc) : n.acc;
  endfunction

  function automatic logic num_end_ok(input num_t n);
    return (n.sub == NUM_DIG) && num_in_range(n);
  endfunction

  // One character into the lenient signed-integer reader.
  function automatic num_step_t num_feed(input num_t n, input logic [7:0] c);
    num_step_t s;
    logic      fin;
    s.n = n;
    s.r = NUM_GO;
    fin = 1'b0;
    if (n.sub == NUM_WS) begin
      if (is_space(c)) begin
        fin = 1'b1;
      end else if ((c == "+") || (c == "-")) begin
        s.n.sign = (c == "-");
        s.n.sub = NUM_SIGN;
        fin = 1'b1;
      end
    end else if ((n.sub == NUM_DIG) && !is_decimal(c)) begin
      s.r = num_in_range(n) ? NUM_OK : NUM_BAD;
      fin = 1'b1;
    end
    if (!fin) begin
      if (!is_decimal(c)) begin
        s.r = NUM_BAD;
      end else begin
        s.n.sub = NUM_DIG;
        s.n = num_add(s.n, c);
      end
    end
    return s;
  endfunction

  // One character into the fraction and offset reader.
  function automatic tail_step_t tail_feed(input tail_t t, input logic [7:0] c);
    tail_step_t s;
    logic       fin;
    s.t = t;
    s.bad = 1'b0;
    fin = 1'b0;
    if (s.t.ph == TL_START) begin
      if (c == ".") begin
        s.t.ph = TL_FRAC;
        fin = 1'b1;
      end else begin
        s.t.ph = TL_SPACE;
      end
    end
    if (!fin && (s.t.ph == TL_FRAC)) begin
      if (is_decimal(c)) fin = 1'b1;
      else s.t.ph = TL_SPACE;
    end
    if (!fin) begin
      case (s.t.ph)
        TL_SPACE: begin
          if (!is_blank(c)) begin
            if ((c == "+") || (c == "-")) begin
              s.t.neg = (c == "-");
              s.t.ph = TL_OH1;
            end else begin
              s.t.ph = TL_DONE;
            end
          end
        end
        TL_OH1: begin
          if (!is_decimal(c)) begin
            s.bad = 1'b1;
          end else begin
            s.t.hours = {3'd0, c[3:0]};
            s.t.ph = TL_OH2;
          end
        end
        TL_OH2: begin
          if (!is_decimal(c)) begin
            s.bad = 1'b1;
          end else begin
            s.t.hours = 7'((s.t.hours << 3) + (s.t.hours << 1) + {3'd0, c[3:0]});
            s.t.ph = TL_COLON;
          end
        end
        TL_COLON, TL_OM1: begin
          if ((s.t.ph == TL_COLON) && (c == ":")) begin
            s.t.ph = TL_OM1;
          end else if (is_decimal(c)) begin
            s.t.mins = {3'd0, c[3:0]};
            s.t.ph = TL_OM2;
          end else begin
            s.t.ph = TL_DONE;
          end
        end
        TL_OM2: begin
          if (!is_decimal(c)) begin
            s.bad = 1'b1;
          end else begin
            s.t.mins = 7'((s.t.mins << 3) + (s.t.mins << 1) + {3'd0, c[3:0]});
            s.t.ph = TL_DONE;
          end
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  function automatic logic tail_end_bad(input tail_t t);
    return (t.ph == TL_OH1) || (t.ph == TL_OH2) || (t.ph == TL_OM2);
  endfunction

  // Classify the unit word; first byte in the top bits. Bit 2 flags a match.
  function automatic logic [2:0] unit_classify(input logic [55:0] w, input logic [2:0] len);
    logic [2:0] r;
    r = 3'b000;
    case (len)
      3'd1: begin
        if (w[55:48] == "s") r = {1'b1, UNIT_SEC};
        else if (w[55:48] == "h") r = {1'b1, UNIT_HOUR};
        else if (w[55:48] == "d") r = {1'b1, UNIT_DAY};
      end
      3'd2: begin
        if (w[55:40] == "hr") r = {1'b1, UNIT_HOUR};
      end
      3'd3: begin
        if (w[55:32] == "sec") r = {1'b1, UNIT_SEC};
        else if (w[55:32] == "min") r = {1'b1, UNIT_MIN};
        else if (w[55:32] == "hrs") r = {1'b1, UNIT_HOUR};
        else if (w[55:32] == "day") r = {1'b1, UNIT_DAY};
      end
      3'd4: begin
        if (w[55:24] == "secs") r = {1'b1, UNIT_SEC};
        else if (w[55:24] == "mins") r = {1'b1, UNIT_MIN};
        else if (w[55:24] == "hour") r = {1'b1, UNIT_HOUR};
        else if (w[55:24] == "days") r = {1'b1, UNIT_DAY};
      end
      3'd5: begin
        if (w[55:16] == "hours") r = {1'b1, UNIT_HOUR};
      end
      3'd6: begin
        if (w[55:8] == "second") r = {1'b1, UNIT_SEC};
        else if (w[55:8] == "minute") r = {1'b1, UNIT_MIN};
      end
      3'd7: begin
        if (w == "seconds") r = {1'b1, UNIT_SEC};
        else if (w == "minutes") r = {1'b1, UNIT_MIN};
      end
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

/* sv/ctu_if.sv */
// Valid/ready channel interfaces for characters in and results out.
interface ctu_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  modport source(output valid, char_code, is_last, input ready);
  modport sink(input valid, char_code, is_last, output ready);
endinterface

interface ctu_res_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [1:0]         unit_code;
  logic signed [31:0] ref_year;
  logic [3:0]         ref_month;
  logic [4:0]         ref_day;
  logic signed [31:0] ref_hour;
  logic signed [31:0] ref_minute;
  logic signed [31:0] ref_second;
  logic signed [11:0] offset_minutes;
  modport source(output valid, valid_res, unit_code, ref_year, ref_month, ref_day,
                 ref_hour, ref_minute, ref_second, offset_minutes, input ready);
  modport sink(input valid, valid_res, unit_code, ref_year, ref_month, ref_day,
               ref_hour, ref_minute, ref_second, offset_minutes, output ready);
endinterface

/* sv/cf_time_units_parser.sv */
// Top level of the streaming CF time-units parser.
// Usage:
//   char_in carries one character of "<unit> since <reference>" per beat,
//   with is_last set on the final character of the string.
//   res_out carries one beat per string, issued for the beat marked last.
//   valid_res is 0 when the string did not decode; all other fields are then 0.
// Timing:
//   A beat is captured in an input register, then parsed into the parse state
//   and, for a last beat, into the result register.
//   Throughput is one character per cycle while no result is stalled; the parse
//   step (a multiply-by-ten accumulate and a phase transition) sets the cycle.
// Reset:
//   rst clears the input and result registers and returns the parser to the
//   start of the unit word. After every result the parser also restarts.
// Stall:
//   While a result waits for res_out.ready, the parse step holds; the input
//   register still takes one beat, then char_in.ready drops until the result
//   is taken.
`include "cf_time_units_parser_defines.svh"

module cf_time_units_parser #(
  parameter int UNIT_CHARS = 16
) (
  input logic      clk,
  input logic      rst,
  ctu_char_if.sink char_in,
  ctu_res_if.source res_out
);
  import ctu_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       advance;
  logic       step_en;

  // Parse state.
  phase_t          phase;
  phase_t          phase_next;
  num_t            num;
  num_t            num_next;
  tail_t           tail;
  tail_t           tail_next;
  logic [5:0][31:0] fields;
  logic [5:0][31:0] fields_next;
  logic            fail;
  logic            fail_next;
  logic [1:0]      unit_sel;
  logic [1:0]      unit_sel_next;
  unit_res_t       ures;

  // Result computed from the state after the step.
  logic        res_ok;
  logic [11:0] res_offset;

  // Result register.
  logic               res_valid;
  logic               r_valid_res;
  logic [1:0]         r_unit_code;
  logic [31:0]        r_year;
  logic [3:0]         r_month;
  logic [4:0]         r_day;
  logic [31:0]        r_hour;
  logic [31:0]        r_minute;
  logic [31:0]        r_second;
  logic [11:0]        r_offset;

  assign advance = !res_valid || res_out.ready;
  assign step_en = s1_valid && advance;
  assign char_in.ready = !s1_valid || advance;

  // Input register takes a beat whenever it is empty or drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      s1_char <= char_in.char_code;
      s1_last <= char_in.is_last;
    end
  end

  ctu_unit #(
    .UNIT_CHARS(UNIT_CHARS)
  ) u_unit (
    .clk      (clk),
    .rst      (rst),
    .step     (step_en && (phase == PH_UNIT)),
    .clear    (step_en && s1_last),
    .char_code(s1_char),
    .res      (ures)
  );

  // One character through the reference parser, then the end of text if due.
  // Each number reader is only entered from its own phase, so it reads the
  // registered number state directly.
  always_comb begin : parse_step
    logic       done;
    logic       zero_end;
    logic       is_min;
    num_step_t  ns;
    tail_step_t ts;
    logic [7:0] c;
    c = s1_char;
    phase_next = phase;
    num_next = num;
    tail_next = tail;
    fields_next = fields;
    fail_next = fail;
    unit_sel_next = unit_sel;
    done = 1'b0;
    zero_end = 1'b0;
    is_min = 1'b0;
    ns = '0;
    ts = '0;

    if (phase == PH_UNIT) begin
      if (ures.found) begin
        if (ures.good) begin
          unit_sel_next = ures.code;
          phase_next = PH_YEAR;
          num_next = NUM_RESET;
        end else begin
          fail_next = 1'b1;
          phase_next = PH_IGNORE;
        end
      end
    end else if (phase != PH_END) begin
      if (c == 8'd0) begin
        zero_end = 1'b1;
      end else begin
        // Date fields.
        if (phase_next inside {PH_YEAR, PH_MONTH, PH_DAY}) begin
          ns = num_feed(num, c);
          num_next = ns.n;
          case (ns.r)
            NUM_GO: done = 1'b1;
            NUM_BAD: begin
              fail_next = 1'b1;
              phase_next = PH_IGNORE;
              done = 1'b1;
            end
            default: begin
              if (phase_next == PH_YEAR) fields_next[0] = num_value(num_next);
              else if (phase_next == PH_MONTH) fields_next[1] = num_value(num_next);
              else fields_next[2] = num_value(num_next);
              if (phase_next == PH_DAY) begin
                phase_next = PH_PRE_T;
              end else if (c == "-") begin
                phase_next = (phase_next == PH_YEAR) ? PH_MONTH : PH_DAY;
                num_next = NUM_RESET;
                done = 1'b1;
              end else begin
                fail_next = 1'b1;
                phase_next = PH_IGNORE;
                done = 1'b1;
              end
            end
          endcase
        end
        // Optional T separator.
        if (!done && (phase_next == PH_PRE_T)) begin
          if (is_blank(c)) begin
            done = 1'b1;
          end else begin
            phase_next = PH_POST_T;
            if ((c == "T") || (c == "t")) done = 1'b1;
          end
        end
        // Start of the time of day, or straight to the offset.
        if (!done && (phase_next == PH_POST_T)) begin
          if (is_blank(c)) begin
            done = 1'b1;
          end else if (is_decimal(c)) begin
            phase_next = PH_HOUR;
            num_next = NUM_RESET;
            num_next.sub = NUM_DIG;
            num_next = num_add(num_next, c);
            done = 1'b1;
          end else begin
            tail_next = TAIL_RESET;
            phase_next = PH_TAIL;
          end
        end
        // Hour.
        if (!done && (phase_next == PH_HOUR)) begin
          ns = num_feed(num, c);
          num_next = ns.n;
          if (ns.r == NUM_GO) begin
            done = 1'b1;
          end else begin
            tail_next = TAIL_RESET;
            if (ns.r == NUM_BAD) begin
              phase_next = PH_IGNORE;
              done = 1'b1;
            end else begin
              fields_next[3] = num_value(num_next);
              if (c == ":") begin
                phase_next = PH_MIN;
                num_next = NUM_RESET;
                done = 1'b1;
              end else begin
                phase_next = PH_TAIL;
              end
            end
          end
        end
        // Minute and second; the offset reader runs alongside.
        if (!done && ((phase_next == PH_MIN) || (phase_next == PH_SEC))) begin
          is_min = (phase_next == PH_MIN);
          ns = num_feed(num, c);
          num_next = ns.n;
          if (ns.r == NUM_OK) begin
            if (is_min) fields_next[4] = num_value(num_next);
            else fields_next[5] = num_value(num_next);
            tail_next = TAIL_RESET;
            if (is_min && (c == ":")) begin
              phase_next = PH_SEC;
              num_next = NUM_RESET;
              done = 1'b1;
            end else begin
              phase_next = PH_TAIL;
            end
          end else begin
            if (ns.r == NUM_BAD) phase_next = PH_TAIL;
            ts = tail_feed(tail_next, c);
            tail_next = ts.t;
            if (ts.bad) begin
              fail_next = 1'b1;
              phase_next = PH_IGNORE;
            end
            done = 1'b1;
          end
        end
        // Fraction and offset.
        if (!done && (phase_next == PH_TAIL)) begin
          ts = tail_feed(tail_next, c);
          tail_next = ts.t;
          if (ts.bad) begin
            fail_next = 1'b1;
            phase_next = PH_IGNORE;
          end
        end
      end
    end

    // End of text: a zero character or the last beat.
    if (zero_end || (s1_last && (phase_next != PH_END))) begin
      case (phase_next)
        PH_UNIT, PH_YEAR, PH_MONTH: fail_next = 1'b1;
        PH_DAY: begin
          if (num_end_ok(num_next)) fields_next[2] = num_value(num_next);
          else fail_next = 1'b1;
        end
        PH_HOUR: begin
          if (num_end_ok(num_next)) fields_next[3] = num_value(num_next);
        end
        PH_MIN, PH_SEC: begin
          if (num_end_ok(num_next)) begin
            if (phase_next == PH_MIN) fields_next[4] = num_value(num_next);
            else fields_next[5] = num_value(num_next);
            tail_next = TAIL_RESET;
          end else if (tail_end_bad(tail_next)) begin
            fail_next = 1'b1;
          end
        end
        PH_TAIL: begin
          if (tail_end_bad(tail_next)) fail_next = 1'b1;
        end
        default: ;
      endcase
      phase_next = PH_END;
    end
  end

  // Result checks and offset in minutes.
  always_comb begin
    res_ok = !fail_next &&
             (fields_next[1] >= 32'd1) && (fields_next[1] <= 32'd12) &&
             (fields_next[2] >= 32'd1) && (fields_next[2] <= 32'd31) &&
             (tail_next.hours <= 7'd23) && (tail_next.mins <= 7'd59);
    res_offset = 12'(tail_next.hours) * 12'd60 + 12'(tail_next.mins);
    if (tail_next.neg) res_offset = 12'd0 - res_offset;
  end

  // Parse state; a last beat returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (step_en && s1_last)) begin
      phase <= PH_UNIT;
      num <= NUM_RESET;
      tail <= TAIL_RESET;
      fields <= {32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0};
      fail <= 1'b0;
      unit_sel <= UNIT_SEC;
    end else if (step_en) begin
      phase <= phase_next;
      num <= num_next;
      tail <= tail_next;
      fields <= fields_next;
      fail <= fail_next;
      unit_sel <= unit_sel_next;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step_en && s1_last) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload; fields are zero when the string did not decode.
  always_ff @(posedge clk) begin
    if (step_en && s1_last) begin
      r_valid_res <= res_ok;
      r_unit_code <= res_ok ? unit_sel_next : 2'd0;
      r_year <= res_ok ? fields_next[0] : 32'd0;
      r_month <= res_ok ? fields_next[1][3:0] : 4'd0;
      r_day <= res_ok ? fields_next[2][4:0] : 5'd0;
      r_hour <= res_ok ? fields_next[3] : 32'd0;
      r_minute <= res_ok ? fields_next[4] : 32'd0;
      r_second <= res_ok ? fields_next[5] : 32'd0;
      r_offset <= res_ok ? res_offset : 12'd0;
    end
  end

  assign res_out.valid = res_valid;
  assign res_out.valid_res = r_valid_res;
  assign res_out.unit_code = r_unit_code;
  assign res_out.ref_year = r_year;
  assign res_out.ref_month = r_month;
  assign res_out.ref_day = r_day;
  assign res_out.ref_hour = r_hour;
  assign res_out.ref_minute = r_minute;
  assign res_out.ref_second = r_second;
  assign res_out.offset_minutes = r_offset;

  // A result appears only after a last beat went through the parse step.
  `CTU_ASSERT(a_res_from_last, clk, rst, $rose(res_valid) |-> $past(step_en && s1_last), "result without a last beat")
  // The parse step holds while a result is stalled.
  `CTU_ASSERT(a_stall_holds, clk, rst, (res_valid && !res_out.ready) |-> !step_en, "parse advanced during stall")
  // A failed decode carries zero fields.
  `CTU_ASSERT(a_zero_fields, clk, rst, (res_valid && !r_valid_res) |-> (r_year == 32'd0 && r_offset == 12'd0 && r_unit_code == 2'd0), "failed result has nonzero fields")
  // The parser restarts after every last beat.
  `CTU_ASSERT(a_restart, clk, rst, (step_en && s1_last) |=> (phase == PH_UNIT), "parser did not restart")
  // Reset empties the result register.
  `CTU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

endmodule

/* sv/ctu_unit.sv */
// Unit-word collector and " since " search over a seven-character window.
module ctu_unit #(
  parameter int UNIT_CHARS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          char_code,
  output ctu_pkg::unit_res_t  res
);
  import ctu_pkg::*;

  localparam int LW = $clog2(UNIT_CHARS + 1);
  localparam int IW = $clog2(UNIT_CHARS);

  logic [55:0]   window;
  logic [55:0]   window_next;
  logic [2:0]    fill;
  logic [2:0]    fill_next;
  logic [7:0]    chars [UNIT_CHARS];
  logic [LW-1:0] len;
  logic [LW-1:0] len_next;
  logic          gap;
  logic          gap_next;
  logic          bad;
  logic          bad_next;
  logic          wr;
  logic [7:0]    lc;
  logic [7:0]    u;
  logic [55:0]   word;
  logic [2:0]    cls;

  // Fold case, shift the window and feed the byte that leaves it to the word.
  always_comb begin
    lc = ((char_code >= "A") && (char_code <= "Z")) ? (char_code | 8'h20) : char_code;
    u = window[55:48];
    gap_next = gap;
    bad_next = bad;
    len_next = len;
    wr = 1'b0;
    if (fill == 3'd7) begin
      if (is_blank(u)) begin
        if (len != '0) gap_next = 1'b1;
      end else if (gap || (len == LW'(UNIT_CHARS))) begin
        bad_next = 1'b1;
      end else begin
        wr = 1'b1;
        len_next = len + LW'(1);
      end
    end
    window_next = {window[47:0], lc};
    fill_next = (fill == 3'd7) ? 3'd7 : fill + 3'd1;
  end

  // First seven bytes of the word as they stand after this character.
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      word[55 - 8*i -: 8] = (wr && (len == LW'(i))) ? u : chars[i];
    end
    cls = unit_classify(word, len_next[2:0]);
    res.found = (fill_next == 3'd7) && (window_next == SINCE_PATTERN);
    res.good = !bad_next && cls[2] && (len_next <= LW'(7));
    res.code = cls[1:0];
  end

  // Control state of the search.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      window <= '0;
      fill <= '0;
      len <= '0;
      gap <= 1'b0;
      bad <= 1'b0;
    end else if (step) begin
      window <= window_next;
      fill <= fill_next;
      len <= len_next;
      gap <= gap_next;
      bad <= bad_next;
    end
  end

  // Word storage, written at the current length.
  always_ff @(posedge clk) begin
    if (step && wr) begin
      chars[len[IW-1:0]] <= u;
    end
  end

endmodule

/* test/ctu_tb_if.sv */
// The testbench takes its channel interfaces from the RTL interface file.

/* test/tb_cf_time_units_parser.sv */
// Testbench for the time-units parser: directed, random and back-pressure strings against a predictor.
module tb_cf_time_units_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import ctu_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [1:0]  unit;
    logic [31:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [31:0] hour;
    logic [31:0] minute;
    logic [31:0] second;
    logic [11:0] offset;
  } decode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ctu_char_if char_in();
  ctu_res_if  res_out();

  cf_time_units_parser dut (.clk(clk), .rst(rst), .char_in(char_in), .res_out(res_out));

  always #2 clk = ~clk;

  // Parser state of the predictor.
  phase_t      phase;
  logic [55:0] window;
  int          fill;
  logic [7:0]  word [16];
  int          word_len;
  logic        word_gap, word_bad;
  logic [1:0]  unit_reg;
  logic [35:0] mag;
  logic        neg;
  num_sub_t    sub;
  logic [31:0] fields [6];
  tl_phase_t   tph;
  logic        tneg;
  int          thours, tmins;
  logic        failed;

  decode_t decode_q[$];
  int errors = 0;
  int idle_free = 0;
  bit hold_go = 0;
  bit hold_used = 0;
  int hold_off = 0;
  int quiet = 0;

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || c == 8'h09;
  endfunction

  task automatic num_reset();
    sub = NUM_WS; neg = 1'b0; mag = '0;
  endtask

  task automatic tail_clear();
    tph = TL_START; tneg = 1'b0; thours = 0; tmins = 0;
  endtask

  task automatic parser_reset();
    phase = PH_UNIT; window = '0; fill = 0; word_len = 0;
    foreach (word[i]) word[i] = 8'd0;
    word_gap = 0; word_bad = 0; unit_reg = UNIT_SEC;
    num_reset();
    fields[0] = 0; fields[1] = 1; fields[2] = 1;
    fields[3] = 0; fields[4] = 0; fields[5] = 0;
    tail_clear();
    failed = 0;
  endtask

  task automatic fail();
    failed = 1; phase = PH_IGNORE;
  endtask

  function automatic bit in_range();
    return mag <= (neg ? 36'h8000_0000 : 36'h7FFF_FFFF);
  endfunction

  function automatic logic [31:0] value();
    return neg ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  function automatic void add_digit(logic [7:0] c);
    mag = mag * 10 + (c - "0");
    if (mag > 36'd2147483649) mag = 36'd2147483649;
  endfunction

  // Returns the number step outcome for one character.
  function automatic num_res_t num_step(logic [7:0] c);
    if (sub == NUM_WS) begin
      if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return NUM_GO;
      if (c == "+" || c == "-") begin
        neg = (c == "-"); sub = NUM_SIGN; return NUM_GO;
      end
    end else if (sub == NUM_DIG && !dig(c)) begin
      return in_range() ? NUM_OK : NUM_BAD;
    end
    if (!dig(c)) return NUM_BAD;
    sub = NUM_DIG;
    add_digit(c);
    return NUM_GO;
  endfunction

  // Fraction and offset reader; returns 1 on malformed offset text.
  function automatic bit tail_step(logic [7:0] c);
    forever begin
      case (tph)
        TL_START: begin
          if (c == ".") begin tph = TL_FRAC; return 0; end
          tph = TL_SPACE;
        end
        TL_FRAC: begin
          if (dig(c)) return 0;
          tph = TL_SPACE;
        end
        TL_SPACE: begin
          if (blank(c)) return 0;
          if (c == "+" || c == "-") begin
            tneg = (c == "-"); tph = TL_OH1; return 0;
          end
          tph = TL_DONE; return 0;
        end
        TL_OH1: begin
          if (!dig(c)) return 1;
          thours = c - "0"; tph = TL_OH2; return 0;
        end
        TL_OH2: begin
          if (!dig(c)) return 1;
          thours = thours * 10 + (c - "0"); tph = TL_COLON; return 0;
        end
        TL_COLON, TL_OM1: begin
          if (tph == TL_COLON && c == ":") begin tph = TL_OM1; return 0; end
          if (dig(c)) begin tmins = c - "0"; tph = TL_OM2; return 0; end
          tph = TL_DONE; return 0;
        end
        TL_OM2: begin
          if (!dig(c)) return 1;
          tmins = tmins * 10 + (c - "0"); tph = TL_DONE; return 0;
        end
        default: return 0;
      endcase
    end
  endfunction

  function automatic bit tail_bad_at_end();
    return tph == TL_OH1 || tph == TL_OH2 || tph == TL_OM2;
  endfunction

  function automatic bit word_is(string s);
    if (s.len() != word_len) return 0;
    for (int i = 0; i < s.len(); i++) if (word[i] != s[i]) return 0;
    return 1;
  endfunction

  // Unit word lookup; -1 when unknown.
  function automatic int word_code();
    if (word_is("s") || word_is("sec") || word_is("secs") || word_is("second") ||
        word_is("seconds")) return UNIT_SEC;
    if (word_is("min") || word_is("mins") || word_is("minute") || word_is("minutes"))
      return UNIT_MIN;
    if (word_is("h") || word_is("hr") || word_is("hrs") || word_is("hour") ||
        word_is("hours")) return UNIT_HOUR;
    if (word_is("d") || word_is("day") || word_is("days")) return UNIT_DAY;
    return -1;
  endfunction

  task automatic unit_char(logic [7:0] c);
    logic [7:0] lc, u;
    int code;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (fill >= 7) begin
      u = window[55:48];
      if (blank(u)) begin
        if (word_len > 0) word_gap = 1;
      end else if (word_gap || word_len >= 16) begin
        word_bad = 1;
      end else begin
        word[word_len] = u; word_len++;
      end
    end
    window = {window[47:0], lc};
    if (fill < 7) fill++;
    if (fill < 7 || window != SINCE_PATTERN) return;
    code = word_code();
    if (word_bad || code < 0) begin fail(); return; end
    unit_reg = code[1:0];
    phase = PH_YEAR;
    num_reset();
  endtask

  task automatic ref_char(logic [7:0] c);
    num_res_t r;
    forever begin
      case (phase)
        PH_YEAR, PH_MONTH, PH_DAY: begin
          r = num_step(c);
          if (r == NUM_GO) return;
          if (r == NUM_BAD) begin fail(); return; end
          fields[phase - PH_YEAR] = value();
          if (phase == PH_DAY) phase = PH_PRE_T;
          else if (c == "-") begin
            phase = phase_t'(phase + 1); num_reset(); return;
          end else begin fail(); return; end
        end
        PH_PRE_T: begin
          if (blank(c)) return;
          phase = PH_POST_T;
          if (c == "T" || c == "t") return;
        end
        PH_POST_T: begin
          if (blank(c)) return;
          if (dig(c)) begin
            phase = PH_HOUR; num_reset(); sub = NUM_DIG; add_digit(c); return;
          end
          tail_clear(); phase = PH_TAIL;
        end
        PH_HOUR: begin
          r = num_step(c);
          if (r == NUM_GO) return;
          tail_clear();
          if (r == NUM_BAD) begin phase = PH_IGNORE; return; end
          fields[3] = value();
          if (c == ":") begin phase = PH_MIN; num_reset(); return; end
          phase = PH_TAIL;
        end
        PH_MIN, PH_SEC: begin
          r = num_step(c);
          if (r == NUM_OK) begin
            fields[phase == PH_MIN ? 4 : 5] = value();
            tail_clear();
            if (phase == PH_MIN && c == ":") begin
              phase = PH_SEC; num_reset(); return;
            end
            phase = PH_TAIL;
          end else begin
            if (r == NUM_BAD) phase = PH_TAIL;
            if (tail_step(c)) fail();
            return;
          end
        end
        PH_TAIL: begin
          if (tail_step(c)) fail();
          return;
        end
        default: return;
      endcase
    end
  endtask

  task automatic ref_end();
    case (phase)
      PH_UNIT, PH_YEAR, PH_MONTH: fail();
      PH_DAY: if (sub == NUM_DIG && in_range()) fields[2] = value(); else fail();
      PH_HOUR: if (sub == NUM_DIG && in_range()) fields[3] = value();
      PH_MIN, PH_SEC: begin
        if (sub == NUM_DIG && in_range()) begin
          fields[phase == PH_MIN ? 4 : 5] = value();
          tail_clear();
        end else if (tail_bad_at_end()) fail();
      end
      PH_TAIL: if (tail_bad_at_end()) fail();
      default: ;
    endcase
    phase = PH_END;
  endtask

  // Advance the predictor by one accepted character; queue a decode on the last one.
  task automatic predict_decode(logic [7:0] c, logic last);
    decode_t d;
    int m;
    if (phase == PH_UNIT) unit_char(c);
    else if (phase != PH_END) begin
      if (c == 8'd0) ref_end(); else ref_char(c);
    end
    if (!last) return;
    if (phase != PH_END) ref_end();
    d = '0;
    if (!failed && fields[1] >= 1 && fields[1] <= 12 && fields[2] >= 1 &&
        fields[2] <= 31 && thours <= 23 && tmins <= 59) begin
      m = thours * 60 + tmins;
      if (tneg) m = -m;
      d.ok = 1; d.unit = unit_reg; d.year = fields[0];
      d.month = fields[1][3:0]; d.day = fields[2][4:0];
      d.hour = fields[3]; d.minute = fields[4]; d.second = fields[5];
      d.offset = m[11:0];
    end
    decode_q.push_back(d);
    parser_reset();
  endtask

  function automatic bit idle_now();
    return idle_free == 0 && $urandom_range(99) < 28;
  endfunction

  // Sends one character beat and waits for its acceptance.
  task automatic send_char(logic [7:0] c, logic last);
    while (idle_now()) begin
      char_in.valid <= 1'b0;
      @(posedge clk);
    end
    char_in.valid <= 1'b1;
    char_in.char_code <= c;
    char_in.is_last <= last;
    do @(posedge clk); while (!char_in.ready);
    predict_decode(c, last);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Stops offering beats and waits for every pending result.
  task automatic drain();
    char_in.valid <= 1'b0;
    do @(posedge clk); while (decode_q.size() != 0);
  endtask

  // Receiver side: random stalls plus the long hold-off.
  always @(posedge clk) begin
    if (rst) res_out.ready <= 1'b0;
    else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_off <= 300;
      res_out.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_out.ready <= 1'b0;
    end else res_out.ready <= idle_free > 0 || $urandom_range(99) >= 28;
  end

  // Compares each result beat with the oldest pending decode.
  always @(posedge clk) begin
    decode_t got, want;
    if (!rst && res_out.valid && res_out.ready) begin
      got = {res_out.valid_res, res_out.unit_code, res_out.ref_year, res_out.ref_month,
             res_out.ref_day, res_out.ref_hour, res_out.ref_minute, res_out.ref_second,
             res_out.offset_minutes};
      if (decode_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = decode_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((char_in.valid && char_in.ready) || (res_out.valid && res_out.ready)) quiet <= 0;
    else if (!rst) quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("cf_time_units_parser: mismatch");
      $finish;
    end
  end

  function automatic string pick(string opts[$]);
    return opts[$urandom_range(opts.size() - 1)];
  endfunction

  function automatic string rnd_num(int maxdig);
    string s = "";
    int n = $urandom_range(maxdig, 1);
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rnd_noise(int n);
    string s = "";
    for (int i = 0; i < n; i++)
      s = {s, string'(8'($urandom_range(255, 1)))};
    return s;
  endfunction

  // Builds a mostly well-formed units string with random content.
  function automatic string rnd_units();
    string s;
    s = {pick('{"", " ", "\t"}),
         pick('{"s", "sec", "SECS", "second", "seconds", "min", "mins", "Minute",
                "minutes", "h", "hr", "hrs", "hour", "hours", "d", "day", "days",
                "fortnight", "da ys", "verylongunitwordxx"}),
         pick('{"", " "}), pick('{" since ", " SINCE ", " Since "})};
    s = {s, pick('{"", "-", "+", " "}), rnd_num($urandom_range(99) < 5 ? 12 : 4), "-",
         rnd_num(2), "-", rnd_num(2)};
    if ($urandom_range(3) != 0)
      s = {s, pick('{"T", "t", " ", ""}), rnd_num(2), ":", rnd_num(2), ":", rnd_num(2)};
    if ($urandom_range(1)) s = {s, ".", rnd_num(3)};
    case ($urandom_range(4))
      0: s = {s, pick('{"Z", "z", " Z"})};
      1: s = {s, pick('{" +", "-", "+"}), rnd_num(2), pick('{":", ""}), rnd_num(2)};
      2: s = {s, rnd_noise($urandom_range(3))};
      default: ;
    endcase
    return s;
  endfunction

  task automatic test_reset();
    parser_reset();
    char_in.valid <= 1'b0;
    char_in.char_code <= 8'd0;
    char_in.is_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    string cases[$] = '{
      "days since 2000-01-01", "Hours SINCE 1970-1-1 00:00:00",
      "seconds since -2147483648-12-31T23:59:59.999Z",
      "d since 2147483648-1-1", "h since 1-0-1", "d since 1-1-32",
      "s since 1-1-1 5:+3", "s since 1-1-1 99999999999:1",
      "d since 1-1-1 1:2:3 -05:30", "d since 1-1-1 +24:00", "d since 1-1-1 +12:3",
      "  sec\t since 1-1-1", "se c since 1-1-1", "d since", "garbage",
      "d since 1-1-1 +0130"};
    foreach (cases[i]) send_string(cases[i]);
    // A zero character ends the reference; the one before " since " is plain.
    send_char("d", 0); send_char(8'd0, 0); send_string(" since 1-2-3");
    send_string("d since 1-2-3"); 
    send_char("d", 0); send_string(" since 4-5-6");
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 6; i++) begin
      if (i == 2) idle_free = 1;
      if (i == 5) idle_free = 0;
      if ($urandom_range(9) == 0) send_string({rnd_noise($urandom_range(20, 1))});
      else send_string(rnd_units());
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering characters.
  task automatic test_backpressure();
    hold_go = 1;
    for (int i = 0; i < 3; i++) send_string("h since 12-3-4");
    drain();
  endtask

  initial begin
    test_reset();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("cf_time_units_parser: match");
    else $display("cf_time_units_parser: mismatch");
    $finish;
  end
endmodule

/* cf_time_units_parser.f */
+incdir+sv
sv/ctu_pkg.sv
sv/ctu_if.sv
sv/ctu_unit.sv
sv/cf_time_units_parser.sv
test/ctu_tb_if.sv
test/tb_cf_time_units_parser.sv
